// ===== sv/sfr_pkg.sv =====
`timescale 1ns / 1ps
package sfr_pkg;

  localparam int GLYPH_COUNT = 96;
  localparam int GLYPH_IW    = $clog2(GLYPH_COUNT);
  // Placement sums stay below 256 for every allowed magnification.
  localparam int SUMW        = 8;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [6:0] CHAR_LAST  = 7'h7F;
  localparam logic [6:0] COL_HALF   = 7'd64;
  localparam logic [6:0] ROW_MAX    = 7'd63;
  localparam logic [7:0] COL_MAX    = 8'd127;
  localparam logic [7:0] ROW_LIMIT  = 8'd64;
  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [2:0] FC_SPACE   = 3'd5;

  typedef struct packed {
    logic [7:0] char_code;
    logic       invert;
  } sfr_in_t;

  typedef struct packed {
    logic [6:0]  col_x;
    logic [5:0]  top_row;
    logic [31:0] column_bits;
    logic        last_column;
  } sfr_out_t;

  typedef struct packed {
    logic load;   // start drawing a printable character
    logic cr;
    logic lf;
    logic step;   // current column beat taken
  } sfr_cmd_t;

  typedef struct packed {
    logic is_print;
    logic is_cr;
    logic is_lf;
    logic last;
  } sfr_stat_t;

  // Five font columns per glyph, column 0 in the top byte, bit 0 at the top.
  localparam logic [39:0] FONT [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00002F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0030300000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h3F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4030403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F50484830, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414087C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h3008102018, 40'h7F5549557F
  };

endpackage

// ===== sv/sfr_ctrl.sv =====
`timescale 1ns / 1ps
module sfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sfr_pkg::sfr_stat_t stat_i,
  output sfr_pkg::sfr_cmd_t  cmd_o
);
  import sfr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;
  logic in_fire;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_RUN);
  assign in_fire     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.load = in_fire && stat_i.is_print;
    cmd_o.cr   = in_fire && stat_i.is_cr;
    cmd_o.lf   = in_fire && stat_i.is_lf;
    cmd_o.step = out_valid_o && out_ready_i;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (cmd_o.step && stat_i.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a character is being drawn");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> out_valid_o)
    else $error("printable character did not start drawing");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step && stat_i.last) |=> in_ready_o)
    else $error("block not free after final column beat");

endmodule

// ===== sv/sfr_datapath.sv =====
`timescale 1ns / 1ps
module sfr_datapath #(
  parameter int MAX_SCALE = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  input  sfr_pkg::sfr_in_t   in_data_i,
  input  sfr_pkg::sfr_cmd_t  cmd_i,
  output sfr_pkg::sfr_stat_t stat_o,
  output sfr_pkg::sfr_out_t  out_data_o
);
  import sfr_pkg::*;

  localparam int SW = $clog2(MAX_SCALE + 1);

  logic [2:0]      scale_q;
  logic [6:0]      cur_col_q;
  logic [5:0]      cur_row_q;
  logic [6:0]      x_q;
  logic [5:0]      y_q;
  logic [39:0]     row_q;
  logic            inv_q;
  logic [2:0]      fc_q;
  logic [SW-1:0]   rep_q;

  logic [SW-1:0]   s_eff;
  logic [SUMW-1:0] w6, h8;
  logic [6:0]      code7;
  logic [6:0]      gidx;
  logic            wrap;
  logic [SUMW-1:0] y_wrap, y_start, x_start, nx, lf_row;
  logic            rep_end;
  logic [7:0]      font_byte, pix;
  logic [MAX_SCALE-1:0][31:0] mag;
  logic [31:0]     col_bits;

  // Effective magnification: zero reads as one, large values saturate.
  always_comb begin
    if (scale_q == 3'd0) begin
      s_eff = SW'(1);
    end else if (int'(scale_q) > MAX_SCALE) begin
      s_eff = SW'(MAX_SCALE);
    end else begin
      s_eff = SW'(scale_q);
    end
  end

  assign w6 = (SUMW'(s_eff) << 2) + (SUMW'(s_eff) << 1);
  assign h8 = SUMW'(s_eff) << 3;

  always_comb begin
    stat_o.is_cr    = (in_data_i.char_code == CHAR_CR);
    stat_o.is_lf    = (in_data_i.char_code == CHAR_LF);
    stat_o.is_print = (in_data_i.char_code >= CHAR_SPACE);
  end

  assign code7 = in_data_i.char_code[7] ? CHAR_LAST : in_data_i.char_code[6:0];
  assign gidx  = code7 - CHAR_SPACE[6:0];

  // Placement of a new character, with right-half overflow.
  always_comb begin
    wrap    = cur_col_q[6] && ((SUMW'(cur_col_q[5:0]) + w6) > SUMW'(ROW_MAX));
    y_wrap  = SUMW'(cur_row_q) + h8;
    if ((y_wrap + h8 > ROW_LIMIT) || (y_wrap > SUMW'(ROW_MAX))) begin
      y_wrap = '0;
    end
    y_start = wrap ? y_wrap : SUMW'(cur_row_q);
    x_start = wrap ? '0 : SUMW'(cur_col_q);
    nx      = x_start + w6;
    lf_row  = SUMW'(cur_row_q) + h8;
  end

  assign rep_end     = (rep_q == s_eff - SW'(1));
  assign stat_o.last = (fc_q == FC_SPACE) && rep_end;

  always_comb begin
    case (fc_q)
      3'd0:    font_byte = row_q[39:32];
      3'd1:    font_byte = row_q[31:24];
      3'd2:    font_byte = row_q[23:16];
      3'd3:    font_byte = row_q[15:8];
      3'd4:    font_byte = row_q[7:0];
      default: font_byte = 8'h00;
    endcase
  end

  assign pix = inv_q ? (font_byte ^ BYTE_ONES) : font_byte;

  // Vertical replication, one fixed wiring per magnification.
  for (genvar sv = 1; sv <= MAX_SCALE; sv++) begin : g_mag
    for (genvar p = 0; p < 32; p++) begin : g_bit
      if (p < 8 * sv) begin : g_on
        localparam int SRC_BIT = p / sv;
        assign mag[sv-1][p] = pix[SRC_BIT];
      end else begin : g_off
        assign mag[sv-1][p] = 1'b0;
      end
    end
  end

  always_comb begin
    col_bits = '0;
    for (int i = 0; i < MAX_SCALE; i++) begin
      if (s_eff == SW'(i + 1)) col_bits = mag[i];
    end
  end

  always_comb begin
    out_data_o.col_x       = x_q;
    out_data_o.top_row     = y_q;
    out_data_o.column_bits = col_bits;
    out_data_o.last_column = stat_o.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= 3'd1;
      cur_col_q <= '0;
      cur_row_q <= '0;
      fc_q      <= '0;
      rep_q     <= '0;
    end else begin
      if (cfg_we_i) scale_q <= cfg_wdata_i;
      if (cmd_i.cr) cur_col_q <= '0;
      if (cmd_i.lf) begin
        cur_row_q <= (lf_row > SUMW'(ROW_MAX)) ? '0 : lf_row[5:0];
      end
      if (cmd_i.load) begin
        cur_col_q <= (nx > COL_MAX) ? '0 : nx[6:0];
        cur_row_q <= y_start[5:0];
        fc_q      <= '0;
        rep_q     <= '0;
      end else if (cmd_i.step) begin
        if (rep_end) begin
          rep_q <= '0;
          fc_q  <= fc_q + 3'd1;
        end else begin
          rep_q <= rep_q + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= x_start[6:0];
      y_q   <= y_start[5:0];
      row_q <= FONT[gidx[GLYPH_IW-1:0]];
      inv_q <= in_data_i.invert;
    end else if (cmd_i.step) begin
      x_q <= x_q + 7'd1;
    end
  end

  a_step_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !cmd_i.load) |=> (x_q == $past(x_q) + 7'd1))
    else $error("column address did not advance");

  a_load_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (fc_q == 3'd0 && rep_q == '0))
    else $error("column counters not cleared on new character");

  a_last_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.last |-> (font_byte == 8'h00))
    else $error("final column is not the spacing column");

endmodule

// ===== sv/scaled_font_text_renderer_unit.sv =====
`timescale 1ns / 1ps
// Printable character: taken while in_ready_o is high, first column beat valid the next cycle,
// then 6*scale beats at one per cycle while out_ready_i stays high.
// No new character is accepted until its final beat has been taken; CR, LF and other control
// codes are taken while idle and produce no column beats.
// Reset (rst_ni low, asynchronous): cursor to column 0 row 0, scale 1, block idle;
// the font is a constant table, so no clearing pass follows reset.
module scaled_font_text_renderer_unit #(
  parameter int MAX_SCALE = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sfr_pkg::sfr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sfr_pkg::sfr_out_t out_data_o
);
  import sfr_pkg::*;

  sfr_cmd_t  cmd;
  sfr_stat_t stat;

  sfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sfr_datapath #(
    .MAX_SCALE (MAX_SCALE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule
